// ===== rtl/scope_trace_renderer_unit_macros.svh =====
// Assertion macros for the scope trace renderer.
`ifndef SCOPE_TRACE_RENDERER_UNIT_MACROS_SVH
`define SCOPE_TRACE_RENDERER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define STR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scope trace renderer: check failed");
`define STR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scope trace renderer: check failed");
`else
`define STR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define STR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/scope_tr_pkg.sv =====
// Types and constants shared by the scope trace renderer.
package scope_tr_pkg;

    localparam int SAMPLE_COUNT_DEF = 128;
    localparam int STRIP_HEIGHT     = 16;
    localparam int ROW_MID          = STRIP_HEIGHT / 2;
    localparam int ROW_MIN          = 2;
    localparam int ROW_MAX          = STRIP_HEIGHT - 3;
    localparam int ROW_SCALE        = STRIP_HEIGHT / 2 - 2;

    localparam int GAIN_NUMER       = 110 * 100;
    localparam int GAIN_PEAK_LIMIT  = 110;
    localparam int GAIN_UNITY       = 100;
    localparam int GAIN_CAP         = 620;
    localparam int GAIN_DIVISOR     = 10000;
    localparam int GAIN_RESET       = 100;

    // ceil(2^32 / GAIN_DIVISOR); exact for magnitudes below 2^20
    localparam int ROW_RECIP        = 429497;
    localparam int ROW_RECIP_SHIFT  = 32;

    localparam int WIDTH_MIN        = 2;
    localparam int WIDTH_MAX        = 1024;
    localparam int WIDTH_RESET      = 240;

    localparam int FRAC_W           = 8;
    localparam int COL_W            = 10;
    localparam int CFG_W            = 11;
    localparam int GAIN_W           = 10;
    localparam int ROW_W            = 4;
    localparam int ROW_QUOT_W       = 20;
    localparam int DEN_W            = 14;

    typedef enum logic
    {
        ACT_LOAD   = 1'b0,
        ACT_RENDER = 1'b1
    } action_t;

    typedef struct packed
    {
        action_t           action;
        logic signed [7:0] sample;
        logic              last_sample;
    } in_item_t;

    typedef struct packed
    {
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] top_row;
        logic [ROW_W-1:0] bottom_row;
        logic             last_column;
    } out_item_t;

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_GAIN_DIV,
        S_COL_DIV,
        S_RD_A,
        S_RD_B,
        S_INTERP,
        S_SMOOTH,
        S_SCALE,
        S_ROW_START,
        S_ROW_DIV,
        S_FINISH
    } state_t;

endpackage

// ===== rtl/scope_tr_ram.sv =====
// Generic single write, single read RAM with registered read data.
module scope_tr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/scope_tr_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
module scope_tr_div #(
    parameter int NUM_W = 25,
    parameter int DEN_W = 14
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [NUM_W-1:0] quot_reg, quot_next;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;

    assign shifted = {rem_reg, quot_reg[NUM_W-1]};
    assign diff    = shifted - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            rem_next  = '0;
            den_next  = denom;
            quot_next = numer;
        end
        else if (busy_reg)
        begin
            if (!diff[DEN_W])
            begin
                rem_next  = diff[DEN_W-1:0];
                quot_next = {quot_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted[DEN_W-1:0];
                quot_next = {quot_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== rtl/scope_trace_renderer_unit.sv =====
// Oscilloscope strip renderer top level: sequencer around a shared divider and sample RAM.
// Usage:
//   in channel  (in_valid / in_stall / in_item): a load item (action 0) writes one sample;
//     a load with last_sample set closes the frame and fixes the gain. A render item
//     (action 1) produces one column span on the out channel.
//   out channel (out_valid / out_stall / out_item): one item per render, in order.
//   cfg_write / cfg_data: display width, written by the user while the block is idle;
//     the block itself leaves this unenforced.
// An ordinary load completes without leaving idle. A frame-closing load with peak below
// 110 waits in the shared divider while it works out the gain. A render runs the divider
// once for the resample position, then RAM reads, the multiply steps and a reciprocal
// multiply for the row scaling.
// A finished column sits in the output register; the next item is accepted while it
// waits. A render reaching its end while the output register is still full holds
// until out_stall drops. in_stall is high whenever an item is in progress.
// Reset: gain 100, peak 1, load and column counts 0, previous row at midline,
// width 240, output empty. Sample RAM is not cleared.
`include "scope_trace_renderer_unit_macros.svh"

module scope_trace_renderer_unit #(
    parameter int SAMPLE_COUNT = scope_tr_pkg::SAMPLE_COUNT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  scope_tr_pkg::in_item_t          in_item,
    output logic                            out_valid,
    input  logic                            out_stall,
    output scope_tr_pkg::out_item_t         out_item,
    input  logic                            cfg_write,
    input  logic [scope_tr_pkg::CFG_W-1:0]  cfg_data
);

    import scope_tr_pkg::*;

    localparam int IDX_W  = $clog2(SAMPLE_COUNT);
    localparam int NUM_W  = COL_W + IDX_W + FRAC_W;
    localparam int DIV_W  = (NUM_W > ROW_QUOT_W) ? NUM_W : ROW_QUOT_W;
    localparam int SPAN_W = COL_W + IDX_W;

    // control state
    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   load_count_reg, load_count_next;
    logic [7:0]         peak_reg, peak_next;
    logic [GAIN_W-1:0]  gain_reg, gain_next;
    logic [COL_W-1:0]   column_count_reg, column_count_next;
    logic [ROW_W-1:0]   prev_row_reg, prev_row_next;
    logic [CFG_W-1:0]   width_reg;
    logic               out_valid_reg, out_valid_next;

    // payload
    logic [COL_W-1:0]   col_reg, col_next;
    logic               last_col_reg, last_col_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   nidx_reg, nidx_next;
    logic [FRAC_W-1:0]  frac_reg, frac_next;
    logic signed [7:0]  a_reg, a_next;
    logic signed [17:0] prod_reg, prod_next;
    logic signed [7:0]  smooth_reg, smooth_next;
    logic signed [18:0] scale_reg, scale_next;
    logic               neg_reg, neg_next;
    logic [38:0]        row_prod_reg, row_prod_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    out_item_t          out_item_reg, out_item_next;

    // divider and RAM hookup
    logic               div_start;
    logic [DIV_W-1:0]   div_numer;
    logic [DEN_W-1:0]   div_denom;
    logic               div_done;
    logic [DIV_W-1:0]   div_quot;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_raddr;
    logic [7:0]         ram_rdata;

    // helpers
    logic               accept;
    logic [CFG_W-1:0]   eff_width;
    logic [COL_W-1:0]   width_m1;
    logic [COL_W-1:0]   col_eff;
    logic [SPAN_W-1:0]  col_span;
    logic [7:0]         sample_mag;
    logic [7:0]         peak_upd;
    logic [IDX_W-1:0]   q_idx;
    logic signed [8:0]  interp_diff;
    logic signed [17:0] interp_round;
    logic signed [17:0] smooth_wide;
    logic signed [19:0] scaled6;
    logic [19:0]        scaled6_mag;
    logic [6:0]         row_quot;
    logic [7:0]         row_delta;
    logic signed [8:0]  row_raw;
    logic               out_free;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        if (width_reg < CFG_W'(WIDTH_MIN))
        begin
            eff_width = CFG_W'(WIDTH_MIN);
        end
        else if (width_reg > CFG_W'(WIDTH_MAX))
        begin
            eff_width = CFG_W'(WIDTH_MAX);
        end
        else
        begin
            eff_width = width_reg;
        end
    end

    assign width_m1   = COL_W'(eff_width - CFG_W'(1));
    assign col_eff    = ({1'b0, column_count_reg} >= eff_width) ? '0 : column_count_reg;
    assign col_span   = SPAN_W'(col_eff) * SPAN_W'(SAMPLE_COUNT - 1);
    assign sample_mag = in_item.sample[7] ? (~in_item.sample + 8'd1) : in_item.sample;
    assign peak_upd   = (sample_mag > peak_reg) ? sample_mag : peak_reg;
    assign q_idx      = div_quot[IDX_W+FRAC_W-1:FRAC_W];

    assign interp_diff  = {ram_rdata[7], ram_rdata} - {a_reg[7], a_reg};
    assign interp_round = prod_reg + (prod_reg[17] ? 18'sd255 : 18'sd0);
    assign smooth_wide  = 18'(a_reg) + (interp_round >>> FRAC_W);
    assign scaled6      = (20'(scale_reg) <<< 2) + (20'(scale_reg) <<< 1);
    assign scaled6_mag  = scaled6[19] ? (~scaled6 + 20'd1) : scaled6;
    assign row_quot     = row_prod_reg[ROW_RECIP_SHIFT+6:ROW_RECIP_SHIFT];
    assign row_delta    = neg_reg ? (8'd0 - {1'b0, row_quot}) : {1'b0, row_quot};
    assign row_raw      = 9'(ROW_MID) - 9'($signed(row_delta));

    always_comb
    begin
        state_next        = state_reg;
        load_count_next   = load_count_reg;
        peak_next         = peak_reg;
        gain_next         = gain_reg;
        column_count_next = column_count_reg;
        prev_row_next     = prev_row_reg;
        out_valid_next    = out_valid_reg && out_stall;
        col_next          = col_reg;
        last_col_next     = last_col_reg;
        idx_next          = idx_reg;
        nidx_next         = nidx_reg;
        frac_next         = frac_reg;
        a_next            = a_reg;
        prod_next         = prod_reg;
        smooth_next       = smooth_reg;
        scale_next        = scale_reg;
        neg_next          = neg_reg;
        row_prod_next     = row_prod_reg;
        row_next          = row_reg;
        out_item_next     = out_item_reg;
        div_start         = 1'b0;
        div_numer         = DIV_W'(col_span) << FRAC_W;
        div_denom         = DEN_W'(width_m1);
        ram_we            = 1'b0;
        ram_raddr         = (state_reg == S_RD_A) ? idx_reg : nidx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && in_item.action == ACT_LOAD)
                begin
                    ram_we = 1'b1;
                    load_count_next = (load_count_reg == IDX_W'(SAMPLE_COUNT - 1)) ?
                                      '0 : load_count_reg + IDX_W'(1);
                    peak_next = peak_upd;
                    if (in_item.last_sample)
                    begin
                        peak_next         = 8'd1;
                        load_count_next   = '0;
                        column_count_next = '0;
                        if (peak_upd < 8'(GAIN_PEAK_LIMIT))
                        begin
                            div_start  = 1'b1;
                            div_numer  = DIV_W'(GAIN_NUMER);
                            div_denom  = DEN_W'(peak_upd);
                            state_next = S_GAIN_DIV;
                        end
                        else
                        begin
                            gain_next = GAIN_W'(GAIN_UNITY);
                        end
                    end
                end
                else if (accept)
                begin
                    div_start         = 1'b1;
                    col_next          = col_eff;
                    last_col_next     = (col_eff == width_m1);
                    column_count_next = (col_eff == width_m1) ? '0 : col_eff + COL_W'(1);
                    if (col_eff == '0)
                    begin
                        prev_row_next = ROW_W'(ROW_MID);
                    end
                    state_next = S_COL_DIV;
                end
            end
            S_GAIN_DIV:
            begin
                if (div_done)
                begin
                    gain_next  = (div_quot > DIV_W'(GAIN_CAP)) ?
                                 GAIN_W'(GAIN_CAP) : div_quot[GAIN_W-1:0];
                    state_next = S_IDLE;
                end
            end
            S_COL_DIV:
            begin
                if (div_done)
                begin
                    idx_next   = q_idx;
                    nidx_next  = (q_idx == IDX_W'(SAMPLE_COUNT - 1)) ? q_idx : q_idx + IDX_W'(1);
                    frac_next  = div_quot[FRAC_W-1:0];
                    state_next = S_RD_A;
                end
            end
            S_RD_A:
            begin
                state_next = S_RD_B;
            end
            S_RD_B:
            begin
                a_next     = $signed(ram_rdata);
                state_next = S_INTERP;
            end
            S_INTERP:
            begin
                prod_next  = 18'(interp_diff) * 18'($signed({1'b0, frac_reg}));
                state_next = S_SMOOTH;
            end
            S_SMOOTH:
            begin
                smooth_next = smooth_wide[7:0];
                state_next  = S_SCALE;
            end
            S_SCALE:
            begin
                scale_next = 19'(smooth_reg) * 19'($signed({1'b0, gain_reg}));
                state_next = S_ROW_START;
            end
            S_ROW_START:
            begin
                // row offset = value * gain * ROW_SCALE / GAIN_DIVISOR, toward zero,
                // by reciprocal multiply on the magnitude
                row_prod_next = 39'(scaled6_mag) * 39'(ROW_RECIP);
                neg_next      = scaled6[19];
                state_next    = S_ROW_DIV;
            end
            S_ROW_DIV:
            begin
                if (row_raw < 9'(ROW_MIN))
                begin
                    row_next = ROW_W'(ROW_MIN);
                end
                else if (row_raw > 9'(ROW_MAX))
                begin
                    row_next = ROW_W'(ROW_MAX);
                end
                else
                begin
                    row_next = row_raw[ROW_W-1:0];
                end
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_item_next.column      = col_reg;
                    out_item_next.top_row     = (row_reg < prev_row_reg) ? row_reg : prev_row_reg;
                    out_item_next.bottom_row  = (row_reg > prev_row_reg) ? row_reg : prev_row_reg;
                    out_item_next.last_column = last_col_reg;
                    prev_row_next             = row_reg;
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            load_count_reg   <= '0;
            peak_reg         <= 8'd1;
            gain_reg         <= GAIN_W'(GAIN_RESET);
            column_count_reg <= '0;
            prev_row_reg     <= ROW_W'(ROW_MID);
            width_reg        <= CFG_W'(WIDTH_RESET);
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            load_count_reg   <= load_count_next;
            peak_reg         <= peak_next;
            gain_reg         <= gain_next;
            column_count_reg <= column_count_next;
            prev_row_reg     <= prev_row_next;
            out_valid_reg    <= out_valid_next;
            if (cfg_write)
            begin
                width_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg      <= col_next;
        last_col_reg <= last_col_next;
        idx_reg      <= idx_next;
        nidx_reg     <= nidx_next;
        frac_reg     <= frac_next;
        a_reg        <= a_next;
        prod_reg     <= prod_next;
        smooth_reg   <= smooth_next;
        scale_reg    <= scale_next;
        neg_reg      <= neg_next;
        row_prod_reg <= row_prod_next;
        row_reg      <= row_next;
        out_item_reg <= out_item_next;
    end

    scope_tr_div #(
        .NUM_W (DIV_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_numer),
        .denom (div_denom),
        .done  (div_done),
        .quot  (div_quot)
    );

    scope_tr_ram #(
        .WIDTH (8),
        .DEPTH (SAMPLE_COUNT)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (load_count_reg),
        .wdata (in_item.sample),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    `STR_ASSERT_IMPL(a_div_done_waiting, clk, rst_n, div_done, (state_reg == S_GAIN_DIV || state_reg == S_COL_DIV))
    `STR_ASSERT_IMPL(a_span_ordered, clk, rst_n, out_valid_reg, (out_item_reg.top_row <= out_item_reg.bottom_row && out_item_reg.top_row >= ROW_W'(ROW_MIN) && out_item_reg.bottom_row <= ROW_W'(ROW_MAX)))
    `STR_ASSERT_NEXT(a_finish_delivers, clk, rst_n, (state_reg == S_FINISH && out_free), (out_valid_reg && state_reg == S_IDLE))

endmodule
